@@ sv/srf_pkg.sv @@
// ============================================================================
// Sliding rank filter package
// Shared constants and transaction types for the sliding rank filter unit.
// ============================================================================
package srf_pkg;

    // Field widths of the transactions at the ports.
    localparam int FIELD_W     = 24;
    localparam int RANK_W      = 6;
    localparam int ZCNT_W      = 6;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEF   = 17;
    localparam int MAG_BITS_DEF = 24;
    localparam int QUEUE_DEPTH  = 4;

    // Configuration register map and reset value.
    localparam int                CFG_ADDR_W    = 2;
    localparam logic [RANK_W-1:0] RANK_RESET    = RANK_W'(8);

    typedef struct packed {
        logic [FIELD_W-1:0] magnitude;
        logic               row_end;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] ranked_value;
        logic               last_of_row;
    } t_out_item;

    // Command passed from the sorting front end to the result sequencer.
    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               emit;
        logic               row_end;
        logic [ZCNT_W-1:0]  zeros;
    } t_cmd;

endpackage

@@ sv/sliding_rank_filter_unit.sv @@
// ============================================================================
// Sliding rank filter unit
// Running rank (median) filter along rows of spectral magnitudes.
// ============================================================================
// Path: front end stage register, command queue, then output register.
// Throughput: one input transaction per cycle and, while the receiver is ready,
// one result per cycle; the result sequencer is the limit, so a row end that
// owes up to WINDOW results holds the input back once the command queue fills.
// Reset: synchronous, active low; it empties the window, the queue and the
// output register and sets rank_select to 8. No clearing pass is needed.
module sliding_rank_filter_unit #(
    parameter int WINDOW   = srf_pkg::WINDOW_DEF,
    parameter int MAG_BITS = srf_pkg::MAG_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input transactions: one magnitude and its row end flag.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  srf_pkg::t_in_item              i_in_data,
    // Result transactions.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output srf_pkg::t_out_item             o_out_data,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // The only register, rank_select, lies at byte address zero. Writes to
    // any other address are ignored and read back as zero.
    logic [srf_pkg::RANK_W-1:0] r_rank;
    logic                       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == '0);
    assign prdata  = cfg_hit ? {{(32 - srf_pkg::RANK_W){1'b0}}, r_rank} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= srf_pkg::RANK_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_rank <= pwdata[srf_pkg::RANK_W-1:0];
        end
    end

    // The front end keeps the window of the current row as a sorted cell
    // array with an age per entry: each accepted transaction slots the new
    // magnitude in and drops the oldest entry once the window is full. A
    // stage later the entry at the configured rank is picked and, together
    // with the count of tail zeros owed at a row end, becomes one command.
    srf_pkg::t_cmd front_cmd;
    logic          front_cmd_valid;
    logic          front_cmd_ready;

    srf_sort_front #(
        .WINDOW   (WINDOW),
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_rank      (r_rank),
        .o_cmd_valid (front_cmd_valid),
        .i_cmd_ready (front_cmd_ready),
        .o_cmd       (front_cmd)
    );

    // The queue lets the front end keep taking magnitudes while the back end
    // is still working through the zeros of a finished row.
    srf_pkg::t_cmd back_cmd;
    logic          back_cmd_valid;
    logic          back_cmd_ready;

    srf_cmd_fifo #(
        .DEPTH (srf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_cmd_valid),
        .o_push_ready (front_cmd_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (back_cmd_valid),
        .i_pop_ready  (back_cmd_ready),
        .o_pop_data   (back_cmd)
    );

    // The back end turns each command into its results, one per cycle, into
    // an output register that takes a new result whenever the old one leaves.
    srf_result_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_cmd_valid),
        .o_cmd_ready (back_cmd_ready),
        .i_cmd       (back_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/srf_sort_front.sv @@
// ============================================================================
// Sliding rank filter sort front end
// Keeps the current row's window as a sorted cell array and issues commands.
// ============================================================================
module srf_sort_front #(
    parameter int WINDOW   = srf_pkg::WINDOW_DEF,
    parameter int MAG_BITS = srf_pkg::MAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  srf_pkg::t_in_item           i_in_data,
    input  logic [srf_pkg::RANK_W-1:0]  i_rank,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output srf_pkg::t_cmd               o_cmd
);

    localparam int AGE_W = $clog2(WINDOW);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0]           WIN_C   = CNT_W'(WINDOW);
    localparam logic [AGE_W-1:0]           OLDEST  = AGE_W'(WINDOW - 1);
    localparam logic [srf_pkg::RANK_W:0]   WIN_R   = (srf_pkg::RANK_W + 1)'(WINDOW);

    // Sorted cells, ascending; entries at or above the fill count are stale.
    logic [MAG_BITS-1:0] r_val [WINDOW];
    logic [AGE_W-1:0]    r_age [WINDOW];
    logic [CNT_W-1:0]    r_count;

    logic [MAG_BITS-1:0] n_val [WINDOW];
    logic [AGE_W-1:0]    n_age [WINDOW];
    logic [CNT_W-1:0]    n_count;

    // Stage register holding the classification of the last accepted item.
    logic                      r_s1_valid;
    logic                      r_s1_emit;
    logic                      r_s1_end;
    logic [srf_pkg::ZCNT_W-1:0] r_s1_zeros;

    logic [MAG_BITS-1:0] new_val;
    logic                full;
    logic [CNT_W-1:0]    del_idx;
    logic [CNT_W-1:0]    count_after;
    logic                le_old [WINDOW+1];
    logic [MAG_BITS-1:0] a_val [WINDOW];
    logic [AGE_W-1:0]    a_age [WINDOW];
    logic                a_le  [WINDOW];
    logic                accept;
    logic                need_push;
    logic                s1_leave;
    logic [IDX_W-1:0]    rank_eff;

    assign new_val     = MAG_BITS'(i_in_data.magnitude);
    assign full        = (r_count == WIN_C);
    assign count_after = full ? WIN_C : r_count + CNT_W'(1);

    always_comb begin
        // The oldest entry leaves once the window is full.
        del_idx = WIN_C;
        if (full) begin
            for (int i = 0; i < WINDOW; i++) begin
                if (r_age[i] == OLDEST) begin
                    del_idx = CNT_W'(i);
                end
            end
        end

        for (int i = 0; i < WINDOW; i++) begin
            le_old[i] = (CNT_W'(i) < r_count) && (r_val[i] <= new_val);
        end
        le_old[WINDOW] = 1'b0;

        // Array with the leaving entry removed and the cells above moved down.
        for (int k = 0; k < WINDOW; k++) begin
            if (CNT_W'(k) < del_idx || k == WINDOW - 1) begin
                a_val[k] = r_val[k];
                a_age[k] = r_age[k];
            end else begin
                a_val[k] = r_val[k + 1];
                a_age[k] = r_age[k + 1];
            end
            if (CNT_W'(k) < del_idx) begin
                a_le[k] = le_old[k];
            end else begin
                a_le[k] = le_old[k + 1];
            end
        end

        // Each cell keeps its entry, takes the new value, or takes its lower neighbour.
        for (int k = 0; k < WINDOW; k++) begin
            if (a_le[k]) begin
                n_val[k] = a_val[k];
                n_age[k] = a_age[k] + AGE_W'(1);
            end else if (k == 0) begin
                n_val[k] = new_val;
                n_age[k] = '0;
            end else if (a_le[k - 1]) begin
                n_val[k] = new_val;
                n_age[k] = '0;
            end else begin
                n_val[k] = a_val[k - 1];
                n_age[k] = a_age[k - 1] + AGE_W'(1);
            end
        end

        n_count = i_in_data.row_end ? '0 : count_after;
    end

    assign need_push  = r_s1_emit || r_s1_end;
    assign s1_leave   = r_s1_valid && (!need_push || i_cmd_ready);
    assign o_in_ready = !r_s1_valid || s1_leave;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_val[k] <= n_val[k];
                r_age[k] <= n_age[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_end   <= 1'b0;
            r_s1_zeros <= '0;
        end else begin
            if (accept) begin
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
                r_s1_emit  <= (count_after == WIN_C);
                r_s1_end   <= i_in_data.row_end;
                if (!i_in_data.row_end) begin
                    r_s1_zeros <= '0;
                end else if (count_after == WIN_C) begin
                    r_s1_zeros <= srf_pkg::ZCNT_W'(WINDOW - 1);
                end else begin
                    r_s1_zeros <= srf_pkg::ZCNT_W'(count_after);
                end
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Out-of-range ranks select the largest entry.
    assign rank_eff = ({1'b0, i_rank} >= WIN_R) ? IDX_W'(WINDOW - 1) : i_rank[IDX_W-1:0];

    assign o_cmd_valid   = r_s1_valid && need_push;
    assign o_cmd.value   = srf_pkg::FIELD_W'(r_val[rank_eff]);
    assign o_cmd.emit    = r_s1_emit;
    assign o_cmd.row_end = r_s1_end;
    assign o_cmd.zeros   = r_s1_zeros;

endmodule

@@ sv/srf_cmd_fifo.sv @@
// ============================================================================
// Sliding rank filter command queue
// Short queue between the sort front end and the result sequencer.
// ============================================================================
module srf_cmd_fifo #(
    parameter int DEPTH = srf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  srf_pkg::t_cmd  i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output srf_pkg::t_cmd  o_pop_data
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    srf_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    logic push;
    logic pop;

    assign o_push_ready = (r_fill != FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

@@ sv/srf_result_back.sv @@
// ============================================================================
// Sliding rank filter result sequencer
// Expands commands into ranked value and tail zeros, one per unstalled cycle.
// ============================================================================
module srf_result_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  srf_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srf_pkg::t_out_item o_out_data
);

    logic                       r_emit_done;
    logic [srf_pkg::ZCNT_W-1:0] r_zero_cnt;
    logic                       r_out_valid;
    srf_pkg::t_out_item         r_out_data;

    logic               produce;
    logic               emitting;
    logic               entry_done;
    srf_pkg::t_out_item n_out_data;

    assign produce  = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign emitting = i_cmd.emit && !r_emit_done;

    always_comb begin
        if (emitting) begin
            entry_done              = (i_cmd.zeros == '0);
            n_out_data.ranked_value = i_cmd.value;
        end else begin
            entry_done              = ((r_zero_cnt + srf_pkg::ZCNT_W'(1)) == i_cmd.zeros);
            n_out_data.ranked_value = '0;
        end
        n_out_data.last_of_row = entry_done && i_cmd.row_end;
    end

    assign o_cmd_ready = produce && entry_done;

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_done <= 1'b0;
            r_zero_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (produce) begin
                r_out_valid <= 1'b1;
                if (entry_done) begin
                    r_emit_done <= 1'b0;
                    r_zero_cnt  <= '0;
                end else if (emitting) begin
                    r_emit_done <= 1'b1;
                end else begin
                    r_zero_cnt <= r_zero_cnt + srf_pkg::ZCNT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ tb/sv/sliding_rank_filter_unit_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Sliding rank filter unit testbench
// Streams rows of magnitudes through the block under randomised flow control
// and checks every result against a rank-selecting window model kept here.
// ============================================================================
module sliding_rank_filter_unit_test;

    import srf_pkg::*;

    // The window length and the rank register width follow the package
    // defaults, which are also the defaults of the block under test.
    localparam int          WIN        = WINDOW_DEF;
    localparam int          RANK_ADDR  = 0;
    // Cycles the receiver refuses results during the deliberate long hold.
    localparam int          LONG_HOLD  = 300;
    // Cycles allowed for work still inside the block once nothing is owed.
    localparam int          SETTLE     = 12;
    localparam int          PHASE_BINS = 35;
    localparam int          MAX_SHOWN  = 10;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_queued_bin;

    // ------------------------------------------------------------------------
    // Clock and the signals that drive the block. Everything starts known.
    // ------------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [31:0]           prdata;
    logic                  pready;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sliding_rank_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Window model. It mirrors what the block holds: the newest magnitudes of
    // the current row, how many of them belong to this row, and the rank
    // currently configured. Expected results are queued in arrival order.
    // ------------------------------------------------------------------------
    logic [FIELD_W-1:0] window_bins [WIN];
    int unsigned        row_fill     = 0;
    logic [RANK_W-1:0]  rank_setting = RANK_RESET;
    t_out_item          expected_ranks [$];

    // Shared by processes; only failures and pending_bins have two writers.
    t_queued_bin        pending_bins [$];
    int unsigned        bins_queued     = 0;
    int unsigned        bins_taken      = 0;
    int unsigned        results_checked = 0;
    int unsigned        rows_queued     = 0;
    int unsigned        failures        = 0;
    int unsigned        max_in_gap      = 0;
    int unsigned        max_out_gap     = 0;
    logic               long_hold_req   = 1'b0;
    logic               long_hold_done  = 1'b0;
    int unsigned        in_wait         = 0;
    int unsigned        rx_wait         = 0;

    initial begin
        foreach (window_bins[k]) window_bins[k] = '0;
    end

    // Rank out of range is clamped to the top of the window, so a large
    // setting simply returns the biggest magnitude. Ties need no special
    // handling: equal values are interchangeable in the sorted order.
    function automatic logic [FIELD_W-1:0] rank_of_window();
        logic [FIELD_W-1:0] sorted_vals [$];
        int unsigned        pos;
        pos = (rank_setting >= WIN) ? WIN - 1 : rank_setting;
        foreach (window_bins[k]) sorted_vals.push_back(window_bins[k]);
        sorted_vals.sort();
        return sorted_vals[pos];
    endfunction

    // Works out every result caused by one accepted magnitude. A full window
    // yields its ranked value; a row end then owes one zero for each window
    // that could not be completed, the last one flagged as end of row.
    function automatic void predict_bin(t_in_item bin);
        t_out_item   res;
        int unsigned owed;
        for (int k = WIN - 1; k > 0; k--) window_bins[k] = window_bins[k-1];
        window_bins[0] = bin.magnitude;
        if (row_fill < WIN) row_fill++;
        if (row_fill == WIN) begin
            res.ranked_value = rank_of_window();
            res.last_of_row  = 1'b0;
            expected_ranks.push_back(res);
        end
        if (bin.row_end) begin
            owed = (row_fill == WIN) ? WIN - 1 : row_fill;
            for (int unsigned k = 0; k < owed; k++) begin
                res.ranked_value = '0;
                res.last_of_row  = 1'b0;
                expected_ranks.push_back(res);
            end
            // A row end always leaves at least one result behind it.
            expected_ranks[expected_ranks.size()-1].last_of_row = 1'b1;
            row_fill = 0;
        end
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what,
                     exp_v, act_v);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Each pending magnitude carries the number of idle cycles that
    // follow it. Valid is held with a steady payload until the transaction
    // is taken, and the model is advanced at the edge of acceptance.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_queued_bin nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait  <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_bin(in_data);
                bins_taken <= bins_taken + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (in_wait != 0) begin
                    in_wait  <= in_wait - 1;
                    in_valid <= 1'b0;
                end else if (pending_bins.size() != 0) begin
                    nxt      = pending_bins.pop_front();
                    in_data  <= nxt.item;
                    in_valid <= 1'b1;
                    in_wait  <= nxt.gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result transaction is compared field by field with the
    // oldest expectation. After every result the receiver draws a stall;
    // once on request it refuses results for a long stretch so that the
    // block backs up and has to hold its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item   exp_r;
        int unsigned draw;
        if (!i_rst_n) begin
            out_ready      <= 1'b0;
            rx_wait        <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_checked <= results_checked + 1;
                if (expected_ranks.size() == 0) begin
                    note_mismatch("unexpected result", '0, 32'(o_out_data));
                end else begin
                    exp_r = expected_ranks.pop_front();
                    if (o_out_data.ranked_value !== exp_r.ranked_value)
                        note_mismatch("ranked_value", 32'(exp_r.ranked_value),
                                      32'(o_out_data.ranked_value));
                    if (o_out_data.last_of_row !== exp_r.last_of_row)
                        note_mismatch("last_of_row", 32'(exp_r.last_of_row),
                                      32'(o_out_data.last_of_row));
                end
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done <= 1'b1;
                rx_wait        <= LONG_HOLD;
                out_ready      <= 1'b0;
            end else if (o_out_valid && out_ready) begin
                draw      = $urandom_range(0, max_out_gap);
                rx_wait   <= draw;
                out_ready <= (draw == 0);
            end else if (rx_wait != 0) begin
                rx_wait   <= rx_wait - 1;
                out_ready <= (rx_wait == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_bin(logic [FIELD_W-1:0] mag, logic last);
        t_queued_bin q;
        q.item.magnitude = mag;
        q.item.row_end   = last;
        q.gap            = $urandom_range(0, max_in_gap);
        pending_bins.push_back(q);
        bins_queued++;
        if (last) rows_queued++;
    endtask

    // One row of random content. The flavour decides whether magnitudes are
    // spread over the whole range, crowded into a few values so that ties
    // are common, or taken from the corners of the range.
    task automatic queue_row(int unsigned len);
        int unsigned        flavour;
        logic [FIELD_W-1:0] mag;
        flavour = $urandom_range(0, 9);
        for (int unsigned k = 0; k < len; k++) begin
            if (flavour < 6)
                mag = FIELD_W'($urandom);
            else if (flavour < 8)
                mag = FIELD_W'($urandom_range(0, 3));
            else
                case ($urandom_range(0, 3))
                    0: mag = '0;
                    1: mag = '1;
                    2: mag = {1'b1, {(FIELD_W-1){1'b0}}};
                    default: mag = FIELD_W'(1);
                endcase
            queue_bin(mag, k == len - 1);
        end
    endtask

    // The sender pauses here until every owed result has come back and the
    // block has had time to finish any magnitude that owes nothing.
    task automatic wait_idle();
        while (bins_taken != bins_queued || expected_ranks.size() != 0 ||
               pending_bins.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(logic [CFG_ADDR_W-1:0] addr, logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) note_mismatch("rank_select readback", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_rank(logic [RANK_W-1:0] r);
        cfg_write(CFG_ADDR_W'(RANK_ADDR * 4), 32'(r));
        rank_setting = r;
        cfg_check(CFG_ADDR_W'(RANK_ADDR * 4), 32'(r));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    // A first row that holds the corners of the range, single set bits,
    // alternating patterns and runs of equal values, long enough to give
    // several ranked results before its tail of zeros.
    localparam logic [FIELD_W-1:0] OPENING_ROW [20] = '{
        24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555, 24'h800000,
        24'h000001, 24'h7FFFFF, 24'h123456, 24'h123456, 24'h123456,
        24'h123456, 24'h123456, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'hABCDEF, 24'h010203, 24'hFEDCBA
    };

    localparam logic [RANK_W-1:0] PHASE_RANK   [7] = '{0, 16, 17, 63, 62, 5, 8};
    localparam int unsigned       PHASE_IN_GAP [7] = '{14, 0, 14, 0, 3, 14, 0};
    localparam int unsigned       PHASE_OUT_GAP[7] = '{0, 14, 14, 0, 3, 14, 0};
    localparam int                HOLD_PHASE       = 3;

    initial begin
        int unsigned phase_bins;
        int unsigned pick;
        int unsigned len;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the rank register must read back its reset value.
        cfg_check(CFG_ADDR_W'(RANK_ADDR * 4), 32'(RANK_RESET));

        // Directed rows at the reset rank: a full row with ties and corner
        // values, then a short row that must give only zeros even though the
        // window still holds older magnitudes, then a row of one item.
        max_in_gap  = 2;
        max_out_gap = 2;
        foreach (OPENING_ROW[k]) queue_bin(OPENING_ROW[k], k == 19);
        queue_bin(24'hFFFFFF, 1'b0);
        queue_bin(24'h000000, 1'b0);
        queue_bin(24'hFFFFFF, 1'b1);
        queue_bin(24'hC0FFEE, 1'b1);
        wait_idle();

        // Random phases, each at a rank and a flow-control mix chosen for it.
        // The ranks include both ends of the window and values beyond it.
        for (int p = 0; p < 7; p++) begin
            if (p == 5)
                set_rank(RANK_W'($urandom_range(1, WIN - 2)));
            else
                set_rank(PHASE_RANK[p]);
            max_in_gap  = PHASE_IN_GAP[p];
            max_out_gap = PHASE_OUT_GAP[p];
            phase_bins  = 0;
            while (phase_bins < PHASE_BINS) begin
                pick = $urandom_range(0, 9);
                if (pick < 3)       len = $urandom_range(1, WIN - 1);
                else if (pick == 3) len = WIN;
                else if (pick == 4) len = 1;
                else if (pick == 9) len = $urandom_range(60, 80);
                else                len = $urandom_range(WIN + 1, 48);
                queue_row(len);
                phase_bins += len;
            end
            // With the sender running flat out, the receiver now stops for a
            // long while so that the block fills and holds its input back.
            if (p == HOLD_PHASE) begin
                @(posedge i_clk);
                long_hold_req <= 1'b1;
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("Ran %0d magnitudes in %0d rows, %0d results checked,", bins_taken,
                 rows_queued, results_checked);
        $display("ranks 0 to 63 incl. out-of-range, with stalls on both sides.");
        if (failures == 0 && expected_ranks.size() == 0) begin
            $display("PASS sliding_rank_filter_unit");
        end else begin
            $display("FAIL sliding_rank_filter_unit");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including every row end
    // owing a full tail and the receiver stalling the longest each time.
    initial begin
        #(20_000_000);
        $display("FAIL sliding_rank_filter_unit");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/srf_pkg.sv
sv/srf_sort_front.sv
sv/srf_cmd_fifo.sv
sv/srf_result_back.sv
sv/sliding_rank_filter_unit.sv
tb/sv/sliding_rank_filter_unit_test.sv
